@@ hdl/ecpr_pkg.sv @@
// shared types and codes for the enhanced clock page replacer
// used by ecpr_cell and enhanced_clock_page_replacer_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ecpr_pkg;

  // operation codes carried in the input tuser
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_ACCESS = 2'd1;
  localparam logic [1:0] MODE_EVICT  = 2'd2;

  // result status codes carried in the output tuser
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  // kind of the token that walks the cell chain
  typedef enum logic [2:0] {
    K_SCAN1 = 3'd0,  // first pass: look for clean, unaccessed slot
    K_SKIP  = 3'd1,  // start of second pass: leave oldest slot for later
    K_SCAN2 = 3'd2,  // second pass: clear accessed bits, take first clear one
    K_WRAP  = 3'd3,  // second pass reaching the oldest slot after the lap
    K_FORCE = 3'd4,  // first valid slot that sees it becomes the victim
    K_LOOK  = 3'd5,  // access lookup
    K_DONE  = 3'd6,  // access hit, rides to the end of the chain
    K_MOVE  = 3'd7   // victim bubbling toward the last cell
  } kind_t;

  typedef struct packed {
    logic  vld;
    kind_t kind;
  } tok_t;

  typedef struct packed {
    logic valid;
    logic acc;
    logic dirty;
  } flag_t;

  // operation-wide controls seen by every cell
  typedef struct packed {
    logic ins;
    logic wr;
  } bcast_t;

endpackage

`default_nettype wire

@@ hdl/ecpr_cell.sv @@
// one slot of the replacer chain: page number, accessed/dirty/valid flags, token stage
// depends on ecpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ecpr_cell #(
  parameter int PAGE_BITS = 20
) (
  input  wire                      clk,
  input  wire                      rst,
  input  ecpr_pkg::tok_t           prev_tok,
  input  wire    [PAGE_BITS-1:0]   prev_page,
  input  ecpr_pkg::flag_t          prev_flags,
  input  wire    [PAGE_BITS-1:0]   next_page,
  input  ecpr_pkg::flag_t          next_flags,
  input  ecpr_pkg::bcast_t         bc,
  input  wire    [PAGE_BITS-1:0]   bc_page,
  output ecpr_pkg::tok_t           tok_out,
  output logic   [PAGE_BITS-1:0]   page,
  output ecpr_pkg::flag_t          flags
);

  ecpr_pkg::tok_t  tok;
  ecpr_pkg::tok_t  tok_next;
  ecpr_pkg::flag_t flags_next;
  logic [PAGE_BITS-1:0] page_next;
  logic stay;

  always_comb begin
    page_next  = page;
    flags_next = flags;
    stay       = 1'b0;
    tok_out    = '{vld: 1'b0, kind: ecpr_pkg::K_SCAN1};

    // insert lands in the first empty slot
    if (bc.ins && !flags.valid && prev_flags.valid) begin
      page_next  = bc_page;
      flags_next = '{valid: 1'b1, acc: 1'b0, dirty: 1'b0};
    end

    // lower neighbor swaps its victim into this slot
    if (prev_tok.vld && prev_tok.kind == ecpr_pkg::K_MOVE) begin
      page_next  = prev_page;
      flags_next = prev_flags;
    end

    if (tok.vld) begin
      unique case (tok.kind)
        ecpr_pkg::K_SCAN1: begin
          if (flags.valid && !flags.acc && !flags.dirty) begin
            stay = 1'b1;
          end else begin
            tok_out = '{vld: 1'b1, kind: ecpr_pkg::K_SCAN1};
          end
        end
        ecpr_pkg::K_SKIP: begin
          tok_out = '{vld: 1'b1, kind: ecpr_pkg::K_SCAN2};
        end
        ecpr_pkg::K_SCAN2: begin
          if (flags.valid && !flags.acc) begin
            stay = 1'b1;
          end else begin
            flags_next.acc = 1'b0;
            tok_out = '{vld: 1'b1, kind: ecpr_pkg::K_SCAN2};
          end
        end
        ecpr_pkg::K_WRAP: begin
          if (flags.valid && !flags.acc) begin
            stay = 1'b1;
          end else begin
            // every slot had a second chance: the second-oldest goes
            flags_next.acc = 1'b0;
            tok_out = '{vld: 1'b1, kind: ecpr_pkg::K_FORCE};
          end
        end
        ecpr_pkg::K_FORCE: begin
          if (flags.valid) begin
            stay = 1'b1;
          end else begin
            tok_out = '{vld: 1'b1, kind: ecpr_pkg::K_FORCE};
          end
        end
        ecpr_pkg::K_LOOK: begin
          if (flags.valid && page == bc_page) begin
            flags_next.acc   = 1'b1;
            flags_next.dirty = flags.dirty | bc.wr;
            tok_out = '{vld: 1'b1, kind: ecpr_pkg::K_DONE};
          end else begin
            tok_out = '{vld: 1'b1, kind: ecpr_pkg::K_LOOK};
          end
        end
        ecpr_pkg::K_DONE: begin
          tok_out = '{vld: 1'b1, kind: ecpr_pkg::K_DONE};
        end
        ecpr_pkg::K_MOVE: begin
          // swap with upper neighbor, victim moves up one slot
          page_next  = next_page;
          flags_next = next_flags;
          tok_out = '{vld: 1'b1, kind: ecpr_pkg::K_MOVE};
        end
      endcase
    end

    tok_next = prev_tok;
    if (stay) begin
      tok_next = '{vld: 1'b1, kind: ecpr_pkg::K_MOVE};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok   <= '{vld: 1'b0, kind: ecpr_pkg::K_SCAN1};
      flags <= '{valid: 1'b0, acc: 1'b0, dirty: 1'b0};
    end else begin
      tok   <= tok_next;
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    page <= page_next;
  end

endmodule

`default_nettype wire

@@ hdl/enhanced_clock_page_replacer_core.sv @@
// enhanced second-chance clock page replacer: top level with control and cell chain
// depends on ecpr_pkg and ecpr_cell
//
// usage: one operation per input transfer on the s_ group, one result per operation
// on the m_ group. s_tuser carries the mode (insert, access, evict) and the write
// flag, s_tdata the page number. m_tdata returns the victim page and its dirty bit,
// m_tuser the status (ok, empty, full, access missed).
// slots live in a chain of SLOT_COUNT cells, oldest in cell 0. a token walks the
// chain one cell per cycle: access lookup, both evict passes, and the removal of
// the victim, which bubbles it to the last cell so later pages keep their order.
// path to m_tvalid: insert into a full store, evict from an empty one and mode three
// go straight to the response state, insert passes through S_INS, access walks the
// chain once; evict ends after the first pass when it finds the victim, after the
// second pass when that one does (or only one page is held) and after a third lap
// when the scan wraps to the oldest slots; the bubble walk overlaps the lap.
// s_tready rises in the same cycle as m_tvalid.
// one operation is in flight at a time; the next input is taken as soon as the
// result sits in the output register, even while the receiver stalls it. a stalled
// result holds m_tdata and m_tuser; the block waits before delivering the next one.
// reset empties every slot and clears the accessed and dirty bits at once.
`timescale 1ns / 1ps
`default_nettype none

module enhanced_clock_page_replacer_core #(
  parameter int SLOT_COUNT = 16,
  parameter int PAGE_BITS  = 20
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // [PAGE_BITS-1:0] page_number, zero padded to whole bytes
  input  wire  [((PAGE_BITS+7)/8)*8-1:0]       s_tdata,
  // [1:0] mode, [2] is_write
  input  wire  [2:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // [PAGE_BITS-1:0] victim_page, [PAGE_BITS] victim_dirty, zero padded
  output logic [((PAGE_BITS+8)/8)*8-1:0]       m_tdata,
  // [1:0] status
  output logic [1:0]                           m_tuser
);

  localparam int OW = ((PAGE_BITS + 8) / 8) * 8;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_RUN  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [PAGE_BITS-1:0] op_page;
  logic                 op_wr;
  logic [PAGE_BITS-1:0] res_page;
  logic                 res_dirty;
  logic [1:0]           res_status;
  logic [PAGE_BITS-1:0] res_page_next;
  logic                 res_dirty_next;
  logic [1:0]           res_status_next;
  logic [OW-1:0]        out_word;

  ecpr_pkg::tok_t   inj;
  ecpr_pkg::bcast_t bc;
  ecpr_pkg::tok_t   tok_q   [SLOT_COUNT+1];
  ecpr_pkg::flag_t  flags_q [SLOT_COUNT];
  logic [PAGE_BITS-1:0] page_q [SLOT_COUNT];

  logic in_xfer;
  logic out_free;
  logic [1:0] in_mode;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign in_mode  = s_tuser[1:0];
  assign out_free = !m_tvalid || m_tready;

  assign tok_q[0] = inj;
  assign bc.ins   = (state == S_INS);
  assign bc.wr    = op_wr;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    ecpr_pkg::flag_t      pf;
    ecpr_pkg::flag_t      nf;
    logic [PAGE_BITS-1:0] pp;
    logic [PAGE_BITS-1:0] np;

    if (i == 0) begin : g_first
      assign pf = '{valid: 1'b1, acc: 1'b0, dirty: 1'b0};
      assign pp = '0;
    end else begin : g_mid
      assign pf = flags_q[i-1];
      assign pp = page_q[i-1];
    end

    if (i == SLOT_COUNT - 1) begin : g_last
      assign nf = '{valid: 1'b0, acc: 1'b0, dirty: 1'b0};
      assign np = '0;
    end else begin : g_up
      assign nf = flags_q[i+1];
      assign np = page_q[i+1];
    end

    ecpr_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .prev_tok   (tok_q[i]),
      .prev_page  (pp),
      .prev_flags (pf),
      .next_page  (np),
      .next_flags (nf),
      .bc         (bc),
      .bc_page    (op_page),
      .tok_out    (tok_q[i+1]),
      .page       (page_q[i]),
      .flags      (flags_q[i])
    );
  end

  always_comb begin
    state_next      = state;
    inj             = '{vld: 1'b0, kind: ecpr_pkg::K_SCAN1};
    res_page_next   = res_page;
    res_dirty_next  = res_dirty;
    res_status_next = res_status;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          res_page_next   = '0;
          res_dirty_next  = 1'b0;
          res_status_next = ecpr_pkg::ST_OK;
          unique case (in_mode)
            ecpr_pkg::MODE_INSERT: begin
              if (flags_q[SLOT_COUNT-1].valid) begin
                res_status_next = ecpr_pkg::ST_FULL;
                state_next      = S_RESP;
              end else begin
                state_next = S_INS;
              end
            end
            ecpr_pkg::MODE_ACCESS: begin
              inj        = '{vld: 1'b1, kind: ecpr_pkg::K_LOOK};
              state_next = S_RUN;
            end
            ecpr_pkg::MODE_EVICT: begin
              if (!flags_q[0].valid) begin
                res_status_next = ecpr_pkg::ST_EMPTY;
                state_next      = S_RESP;
              end else begin
                inj        = '{vld: 1'b1, kind: ecpr_pkg::K_SCAN1};
                state_next = S_RUN;
              end
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_INS: begin
        state_next = S_RESP;
      end
      S_RUN: begin
        if (tok_q[SLOT_COUNT].vld) begin
          unique case (tok_q[SLOT_COUNT].kind)
            ecpr_pkg::K_DONE: begin
              state_next = S_RESP;
            end
            ecpr_pkg::K_LOOK: begin
              res_status_next = ecpr_pkg::ST_MISS;
              state_next      = S_RESP;
            end
            ecpr_pkg::K_SCAN1: begin
              // single resident page goes at once
              if (!flags_q[1].valid) begin
                inj = '{vld: 1'b1, kind: ecpr_pkg::K_FORCE};
              end else begin
                inj = '{vld: 1'b1, kind: ecpr_pkg::K_SKIP};
              end
            end
            ecpr_pkg::K_SCAN2: begin
              inj = '{vld: 1'b1, kind: ecpr_pkg::K_WRAP};
            end
            ecpr_pkg::K_MOVE: begin
              // victim sits in the last cell during this cycle
              res_page_next  = page_q[SLOT_COUNT-1];
              res_dirty_next = flags_q[SLOT_COUNT-1].dirty;
              state_next     = S_RESP;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_word                = '0;
    out_word[PAGE_BITS-1:0] = res_page;
    out_word[PAGE_BITS]     = res_dirty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_page   <= res_page_next;
    res_dirty  <= res_dirty_next;
    res_status <= res_status_next;
    if (in_xfer) begin
      op_page <= s_tdata[PAGE_BITS-1:0];
      op_wr   <= s_tuser[2];
    end
    if (state == S_RESP && out_free) begin
      m_tdata <= out_word;
      m_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire

@@ sim/enhanced_clock_page_replacer_core_test.sv @@
// self-checking testbench for enhanced_clock_page_replacer_core: directed and random
// insert, access and evict traffic, results checked against an in-bench predictor
// depends on ecpr_pkg and the core with its cell chain
`timescale 1ns / 1ps

module enhanced_clock_page_replacer_core_test;

  localparam int SLOTS       = 16;
  localparam int PAGE_W      = 20;
  localparam int S_DATA_W    = ((PAGE_W + 7) / 8) * 8;
  localparam int M_DATA_W    = ((PAGE_W + 8) / 8) * 8;
  localparam int RANDOM_OPS  = 1800;
  localparam int DRAIN_WAIT  = 4 * SLOTS + 8;
  localparam int STALL_LIMIT = 2000;

  // mode three has no code in the package; the block changes nothing and returns an ok result
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              dirty;
    logic [1:0]        status;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // [19:0] page_number
  logic [2:0]          s_tuser;   // [1:0] mode, [2] is_write
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;   // [19:0] victim_page, [20] victim_dirty
  logic [1:0]          m_tuser;   // [1:0] status

  // predictor copy of the resident pages, oldest first
  logic [PAGE_W-1:0] held_page [SLOTS];
  bit                held_acc  [SLOTS];
  bit                held_dirty[SLOTS];
  int                held_count;

  outcome_t awaited[$];
  int       mismatches = 0;
  bit       steady = 1'b0;
  int       hold_off = 0;
  int       quiet_cycles = 0;

  int n_insert = 0, n_full = 0, n_access = 0, n_miss = 0;
  int n_evict = 0, n_empty = 0, n_dirty_victim = 0, n_ignored = 0;

  enhanced_clock_page_replacer_core #(
    .SLOT_COUNT(SLOTS),
    .PAGE_BITS (PAGE_W)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  // choose a victim slot; predict_replacement removes it and shifts the younger pages down
  function automatic int pick_victim_slot();
    int v;
    int i;
    v = -1;
    for (int s = 0; s < held_count; s++) begin
      if (!held_acc[s] && !held_dirty[s]) begin
        v = s;
        break;
      end
    end
    if (v < 0 && held_count < 2) begin
      v = 0;
    end else if (v < 0) begin
      for (int k = 0; k < held_count; k++) begin
        i = (k + 1 < held_count) ? k + 1 : 0;
        if (held_acc[i]) begin
          held_acc[i] = 1'b0;
        end else begin
          v = i;
          break;
        end
      end
      if (v < 0) v = 1;
    end
    return v;
  endfunction

  function automatic outcome_t predict_replacement(input logic [1:0] mode,
                                                   input logic [PAGE_W-1:0] page,
                                                   input logic wr);
    outcome_t res;
    int v;
    res = '0;
    res.status = ecpr_pkg::ST_OK;
    case (mode)
      ecpr_pkg::MODE_INSERT: begin
        if (held_count >= SLOTS) begin
          res.status = ecpr_pkg::ST_FULL;
        end else begin
          held_page[held_count]  = page;
          held_acc[held_count]   = 1'b0;
          held_dirty[held_count] = 1'b0;
          held_count++;
        end
      end
      ecpr_pkg::MODE_ACCESS: begin
        res.status = ecpr_pkg::ST_MISS;
        for (int s = 0; s < held_count; s++) begin
          if (held_page[s] == page) begin
            held_acc[s] = 1'b1;
            if (wr) held_dirty[s] = 1'b1;
            res.status = ecpr_pkg::ST_OK;
            break;
          end
        end
      end
      ecpr_pkg::MODE_EVICT: begin
        if (held_count == 0) begin
          res.status = ecpr_pkg::ST_EMPTY;
        end else begin
          v = pick_victim_slot();
          res.page  = held_page[v];
          res.dirty = held_dirty[v];
          for (int s = v; s + 1 < held_count; s++) begin
            held_page[s]  = held_page[s+1];
            held_acc[s]   = held_acc[s+1];
            held_dirty[s] = held_dirty[s+1];
          end
          held_count--;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // one operation per transfer; s_tvalid stays high between back-to-back items
  task automatic send_op(input logic [1:0] mode, input logic [PAGE_W-1:0] page,
                         input logic wr);
    outcome_t res;
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - PAGE_W){1'b0}}, page};
    s_tuser  <= {wr, mode};
    do @(posedge clk); while (!s_tready);
    res = predict_replacement(mode, page, wr);
    awaited.push_back(res);
    case (mode)
      ecpr_pkg::MODE_INSERT: begin
        n_insert++;
        if (res.status == ecpr_pkg::ST_FULL) n_full++;
      end
      ecpr_pkg::MODE_ACCESS: begin
        n_access++;
        if (res.status == ecpr_pkg::ST_MISS) n_miss++;
      end
      ecpr_pkg::MODE_EVICT: begin
        n_evict++;
        if (res.status == ecpr_pkg::ST_EMPTY) n_empty++;
        if (res.dirty) n_dirty_victim++;
      end
      default: n_ignored++;
    endcase
  endtask

  function automatic logic [PAGE_W-1:0] pick_page();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PAGE_W'($urandom_range(0, 7));  // small pool, gives duplicates
      default: return PAGE_W'($urandom());
    endcase
  endfunction

  task automatic test_empty_store();
    send_op(ecpr_pkg::MODE_ACCESS, '1, 1'b1);
    send_op(MODE_IGNORED, '1, 1'b1);
  endtask

  // both pages accessed and dirty: second pass clears the lap, takes the younger one
  task automatic test_second_chance();
    send_op(ecpr_pkg::MODE_INSERT, '0, 1'b0);
    send_op(ecpr_pkg::MODE_INSERT, '1, 1'b1);
    send_op(ecpr_pkg::MODE_ACCESS, '0, 1'b1);
    send_op(ecpr_pkg::MODE_ACCESS, '1, 1'b1);
    send_op(ecpr_pkg::MODE_EVICT, '0, 1'b0);
    send_op(ecpr_pkg::MODE_EVICT, '1, 1'b1);
    send_op(ecpr_pkg::MODE_EVICT, '0, 1'b0);
  endtask

  // access marks only the oldest copy, so the clean younger copy is the victim
  task automatic test_duplicate_pages();
    send_op(ecpr_pkg::MODE_INSERT, 20'h5a5a5, 1'b0);
    send_op(ecpr_pkg::MODE_INSERT, 20'h5a5a5, 1'b0);
    send_op(ecpr_pkg::MODE_ACCESS, 20'h5a5a5, 1'b0);
    send_op(ecpr_pkg::MODE_EVICT, 20'ha5a5a, 1'b1);
  endtask

  task automatic test_full_store();
    for (int i = 1; i < SLOTS; i++) begin
      send_op(ecpr_pkg::MODE_INSERT, (i % 2) ? PAGE_W'(20'hfffff - i) : PAGE_W'(i), 1'b0);
    end
    send_op(ecpr_pkg::MODE_INSERT, 20'h12345, 1'b1);
  endtask

  task automatic test_random_traffic();
    int done_ops;
    int fill_target;
    int r;
    logic [PAGE_W-1:0] page;
    done_ops = 0;
    fill_target = SLOTS;
    while (done_ops < RANDOM_OPS) begin
      if (done_ops % 60 == 0) fill_target = $urandom_range(0, SLOTS + 1);
      if (done_ops % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      if (done_ops >= RANDOM_OPS - 200) steady = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_op(MODE_IGNORED, pick_page(), 1'($urandom()));
      end else begin
        if (r < 45) begin
          if (held_count > 0 && $urandom_range(0, 4) != 0)
            page = held_page[$urandom_range(0, held_count - 1)];
          else
            page = pick_page();
          send_op(ecpr_pkg::MODE_ACCESS, page, 1'($urandom()));
        end else if ((held_count < fill_target) == (r < 85)) begin
          send_op(ecpr_pkg::MODE_INSERT, pick_page(), 1'($urandom()));
        end else begin
          send_op(ecpr_pkg::MODE_EVICT, pick_page(), 1'($urandom()));
        end
        done_ops++;
      end
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      hold_off <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got page %h dirty %b status %0d",
                 $time, m_tdata[PAGE_W-1:0], m_tdata[PAGE_W], m_tuser);
      end else begin
        want = awaited.pop_front();
        if (m_tdata[PAGE_W-1:0] !== want.page)
          report_mismatch("victim_page", 32'(want.page), 32'(m_tdata[PAGE_W-1:0]));
        if (m_tdata[PAGE_W] !== want.dirty)
          report_mismatch("victim_dirty", 32'(want.dirty), 32'(m_tdata[PAGE_W]));
        if (m_tuser !== want.status)
          report_mismatch("status", 32'(want.status), 32'(m_tuser));
      end
    end
  end

  // counts cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, awaited.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    held_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_store();
    test_second_chance();
    test_duplicate_pages();
    test_full_store();
    test_random_traffic();
    s_tvalid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d inserts (%0d into a full store), %0d accesses (%0d missed)",
             n_insert, n_full, n_access, n_miss);
    $display("covered %0d evicts (%0d on an empty store, %0d dirty victims), %0d ignored",
             n_evict, n_empty, n_dirty_victim, n_ignored);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ecpr_pkg.sv
hdl/ecpr_cell.sv
hdl/enhanced_clock_page_replacer_core.sv
sim/enhanced_clock_page_replacer_core_test.sv
